FILE: hdl/wtsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared types, constants and helpers for the world-to-screen projection.
// ----------------------------------------------------------------------------
package wtsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int CFG_DW        = 64;
  localparam int CFG_IW        = 3;
  localparam int SIZE_W        = 14;
  localparam int DIV_STEP      = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_ROW0_XY = 3'd0,
    REG_ROW0_ZW = 3'd1,
    REG_ROW1_XY = 3'd2,
    REG_ROW1_ZW = 3'd3,
    REG_ROW3_XY = 3'd4,
    REG_ROW3_ZW = 3'd5,
    REG_SCR_W   = 3'd6,
    REG_SCR_H   = 3'd7
  } reg_idx_t;

  localparam logic [SIZE_W-1:0] SCR_W_RST = 14'd1920;
  localparam logic [SIZE_W-1:0] SCR_H_RST = 14'd1080;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } wtsp_in_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               in_front;
  } wtsp_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] vmax;
    logic signed [63:0] vmin;
    vmax = 64'sh0000_0000_7FFF_FFFF;
    vmin = -64'sh0000_0000_8000_0000;
    if (v > vmax) begin
      return 32'sh7FFF_FFFF;
    end else if (v < vmin) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

FILE: hdl/wtsp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_div
// Pipelined unsigned restoring divider, STEP quotient bits per stage.
// ----------------------------------------------------------------------------
module wtsp_div import wtsp_pkg::*; #(
  parameter int QP   = 48,
  parameter int DW   = 32,
  parameter int STEP = DIV_STEP
) (
  input  logic          clk,
  input  logic          en,
  input  logic [QP-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QP-1:0] quo
);

  localparam int D = QP / STEP;

  logic [DW-1:0] rem_r [D];
  logic [QP-1:0] num_r [D];
  logic [QP-1:0] q_r   [D];
  logic [DW-1:0] den_r [D];

  for (genvar g = 0; g < D; g++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QP-1:0] num_in;
    logic [QP-1:0] q_in;
    logic [DW-1:0] den_in;
    logic [DW-1:0] rem_next;
    logic [QP-1:0] num_next;
    logic [QP-1:0] q_next;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_rest
      assign rem_in = rem_r[g-1];
      assign num_in = num_r[g-1];
      assign q_in   = q_r[g-1];
      assign den_in = den_r[g-1];
    end

    always_comb begin
      logic [DW:0] t;
      rem_next = rem_in;
      num_next = num_in;
      q_next   = q_in;
      for (int i = 0; i < STEP; i++) begin
        t        = {rem_next, num_next[QP-1]};
        num_next = {num_next[QP-2:0], 1'b0};
        if (t >= {1'b0, den_in}) begin
          t      = t - {1'b0, den_in};
          q_next = {q_next[QP-2:0], 1'b1};
        end else begin
          q_next = {q_next[QP-2:0], 1'b0};
        end
        rem_next = t[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_next;
        num_r[g] <= num_next;
        q_r[g]   <= q_next;
        den_r[g] <= den_in;
      end
    end
  end

  assign quo = q_r[D-1];

endmodule

FILE: hdl/world_to_screen_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Projects a Q-format world point through three view-projection rows to
// pixel coordinates, with a behind-camera bypass.
// ----------------------------------------------------------------------------
//   channel | signals                       | payload
//   in      | in_valid / in_stall           | world_x, world_y, world_z
//   out     | out_valid / out_stall         | screen_x, screen_y, in_front
//   cfg     | cfg_we / cfg_index / cfg_data | eight registers, write only
//
// One point per clock while the output is not stalled. The pipelined divider,
// at four quotient bits per stage, makes up most of the pipeline.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
// A stall on a valid output freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
module world_to_screen_projection import wtsp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  wtsp_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wtsp_out_t         out_data
);

  localparam int QW   = 32 + FRAC_BITS;
  localparam int D    = (QW + DIV_STEP - 1) / DIV_STEP;
  localparam int QP   = D * DIV_STEP;
  localparam int THR  = ((1 << FRAC_BITS) + 50) / 100;
  localparam int SW   = 50;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);

  logic [CFG_DW-1:0] coef [6];
  logic [SIZE_W-1:0] scr_w;
  logic [SIZE_W-1:0] scr_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) coef[i] <= '0;
      scr_w <= SCR_W_RST;
      scr_h <= SCR_H_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROW0_XY: coef[0] <= cfg_data;
        REG_ROW0_ZW: coef[1] <= cfg_data;
        REG_ROW1_XY: coef[2] <= cfg_data;
        REG_ROW1_ZW: coef[3] <= cfg_data;
        REG_ROW3_XY: coef[4] <= cfg_data;
        REG_ROW3_ZW: coef[5] <= cfg_data;
        REG_SCR_W:   scr_w   <= cfg_data[SIZE_W-1:0];
        REG_SCR_H:   scr_h   <= cfg_data[SIZE_W-1:0];
        default:     scr_w   <= scr_w;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: nine products
  logic               v1;
  logic signed [63:0] prod [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= $signed(coef[2*r][31:0])  * in_data.world_x;
        prod[r][1] <= $signed(coef[2*r][63:32]) * in_data.world_y;
        prod[r][2] <= $signed(coef[2*r+1][31:0]) * in_data.world_z;
      end
    end
  end

  // Stage 2: sum, floor to Q, saturate
  logic               v2;
  logic signed [31:0] dot_next [3];
  logic signed [31:0] cx2, cy2, w2;

  always_comb begin
    logic signed [65:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = 66'(prod[r][0]) + 66'(prod[r][1]) + 66'(prod[r][2])
          + (66'($signed(coef[2*r+1][63:32])) <<< FRAC_BITS);
      acc = acc >>> FRAC_BITS;
      dot_next[r] = sat32(acc[63:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx2 <= dot_next[0];
      cy2 <= dot_next[1];
      w2  <= dot_next[2];
    end
  end

  // Stage 3: magnitudes and front test
  logic               v3, front3, negx3, negy3;
  logic signed [31:0] cx3, cy3;
  logic [31:0]        w3;
  logic [QP-1:0]      numx3, numy3;
  logic [31:0]        magx, magy;

  assign magx = cx2[31] ? 32'(-cx2) : 32'(cx2);
  assign magy = cy2[31] ? 32'(-cy2) : 32'(cy2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front3 <= (w2 >= $signed(32'(THR)));
      negx3  <= cx2[31];
      negy3  <= cy2[31];
      cx3    <= cx2;
      cy3    <= cy2;
      // behind points still flow through the divider; keep its divisor sane
      w3     <= (w2 >= $signed(32'(THR))) ? 32'(w2) : 32'd1;
      numx3  <= QP'(magx) << FRAC_BITS;
      numy3  <= QP'(magy) << FRAC_BITS;
    end
  end

  logic [QP-1:0] qx, qy;

  wtsp_div #(.QP(QP), .DW(32), .STEP(DIV_STEP)) u_div_x (
    .clk (clk), .en (en), .num (numx3), .den (w3), .quo (qx)
  );

  wtsp_div #(.QP(QP), .DW(32), .STEP(DIV_STEP)) u_div_y (
    .clk (clk), .en (en), .num (numy3), .den (w3), .quo (qy)
  );

  // Side data runs alongside the divider stages
  logic               vd     [D];
  logic               frontd [D];
  logic               negxd  [D];
  logic               negyd  [D];
  logic signed [31:0] cxd    [D];
  logic signed [31:0] cyd    [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) vd[i] <= 1'b0;
    end else if (en) begin
      vd[0] <= v3;
      for (int i = 1; i < D; i++) vd[i] <= vd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frontd[0] <= front3;
      negxd[0]  <= negx3;
      negyd[0]  <= negy3;
      cxd[0]    <= cx3;
      cyd[0]    <= cy3;
      for (int i = 1; i < D; i++) begin
        frontd[i] <= frontd[i-1];
        negxd[i]  <= negxd[i-1];
        negyd[i]  <= negyd[i-1];
        cxd[i]    <= cxd[i-1];
        cyd[i]    <= cyd[i-1];
      end
    end
  end

  // Stage 4: signed, saturated ndc times screen size
  function automatic logic signed [31:0] ndc_of(input logic [QP-1:0] q, input logic neg);
    logic [QP-1:0] lim;
    lim = QP'(32'h8000_0000);
    if (neg) begin
      if (q >= lim) return -32'sh8000_0000;
      return 32'(-$signed({1'b0, q[31:0]}));
    end
    if (q >= lim) return 32'sh7FFF_FFFF;
    return $signed(q[31:0]);
  endfunction

  logic               v4, front4;
  logic signed [31:0] cx4, cy4;
  logic signed [46:0] px4, py4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vd[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front4 <= frontd[D-1];
      cx4    <= cxd[D-1];
      cy4    <= cyd[D-1];
      px4    <= ndc_of(qx, negxd[D-1]) * $signed({1'b0, scr_w});
      py4    <= ndc_of(qy, negyd[D-1]) * $signed({1'b0, scr_h});
    end
  end

  // Stage 5: center offset, rounding, saturation into the output register; behind points pass clip x/y
  logic signed [SW-1:0] tx, ty, bx, by, sx_full, sy_full;

  always_comb begin
    tx = SW'(px4 >>> 1);
    ty = SW'(py4 >>> 1);
    bx = $signed(SW'(scr_w[SIZE_W-1:1]) << FRAC_BITS);
    by = $signed(SW'(scr_h[SIZE_W-1:1]) << FRAC_BITS);
    sx_full = bx + tx + HALF;
    sy_full = by - (ty + HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.in_front <= front4;
      if (front4) begin
        out_data.screen_x <= sat32(64'(sx_full));
        out_data.screen_y <= sat32(64'(sy_full));
      end else begin
        out_data.screen_x <= cx4;
        out_data.screen_y <= cy4;
      end
    end
  end

endmodule

FILE: hdl/wtsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_checker
// Port-level checks for the world-to-screen projection.
// ----------------------------------------------------------------------------
module wtsp_checker import wtsp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input wtsp_out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // input backpressure follows a blocked output only
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall without blocked output");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind world_to_screen_projection wtsp_checker u_wtsp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// World-to-screen projection testbench
// Drives world points with random gaps and output stalls, predicts each
// projected pixel result in fixed point, and checks results in order. The
// matrix rows and screen size are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
module tb;
  import wtsp_pkg::*;

  localparam int FB      = FRAC_BITS_DEF;
  localparam int LAT     = 5 + (32 + FB + 3) / 4;
  localparam int MAX_CYC = 2000000;

  // Register image and expected pixel results
  class proj_scoreboard;
    logic [63:0] regs [NUM_REGS];
    wtsp_out_t   pending [$];
    int          errors;
    int          shown;

    function void clear_regs();
      foreach (regs[i]) regs[i] = '0;
      regs[REG_SCR_W] = 64'(SCR_W_RST);
      regs[REG_SCR_H] = 64'(SCR_H_RST);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Exact 96-bit sum, floored to Q format, then clamped
    function longint row_dot(logic [63:0] xy, logic [63:0] zw, longint p[3]);
      logic signed [95:0] acc;
      logic signed [95:0] fl;
      longint c[3];
      c[0] = longint'($signed(xy[31:0]));
      c[1] = longint'($signed(xy[63:32]));
      c[2] = longint'($signed(zw[31:0]));
      acc = 96'(signed'(longint'($signed(zw[63:32])))) <<< FB;
      for (int i = 0; i < 3; i++) acc += 96'(signed'(c[i] * p[i]));
      fl = acc >>> FB;
      if (fl > 96'sd2147483647) return 64'sd2147483647;
      if (fl < -96'sd2147483648) return -64'sd2147483648;
      return longint'(fl);
    endfunction

    function longint scale_term(longint clip, longint w, longint sz);
      longint ndc;
      ndc = clamp32((clip * (64'sd1 <<< FB)) / w);
      return (ndc * sz) >>> 1;
    endfunction

    function void note_point(wtsp_in_t pt);
      longint p[3];
      longint cx, cy, w, wd, ht, thr, half;
      wtsp_out_t r;
      p[0] = pt.world_x; p[1] = pt.world_y; p[2] = pt.world_z;
      cx = row_dot(regs[REG_ROW0_XY], regs[REG_ROW0_ZW], p);
      cy = row_dot(regs[REG_ROW1_XY], regs[REG_ROW1_ZW], p);
      w  = row_dot(regs[REG_ROW3_XY], regs[REG_ROW3_ZW], p);
      wd = longint'(regs[REG_SCR_W][SIZE_W-1:0]);
      ht = longint'(regs[REG_SCR_H][SIZE_W-1:0]);
      thr = ((64'sd1 <<< FB) + 50) / 100;
      half = 64'sd1 <<< (FB - 1);
      if (w < thr) begin
        r.screen_x = cx[31:0];
        r.screen_y = cy[31:0];
        r.in_front = 1'b0;
      end else begin
        r.screen_x = 32'(clamp32((wd >>> 1) * (64'sd1 <<< FB)
                     + scale_term(cx, w, wd) + half));
        r.screen_y = 32'(clamp32((ht >>> 1) * (64'sd1 <<< FB)
                     - (scale_term(cy, w, ht) + half)));
        r.in_front = 1'b1;
      end
      pending.push_back(r);
    endfunction

    function void check_pixel(wtsp_out_t got);
      wtsp_out_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (shown++ < 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.screen_x !== exp_r.screen_x || got.screen_y !== exp_r.screen_y ||
          got.in_front !== exp_r.in_front) begin
        errors++;
        if (shown++ < 10)
          $display("mismatch: exp x=%h y=%h f=%b got x=%h y=%h f=%b",
                   exp_r.screen_x, exp_r.screen_y, exp_r.in_front,
                   got.screen_x, got.screen_y, got.in_front);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  wtsp_in_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  wtsp_out_t         out_data;

  proj_scoreboard sb = new();
  int  cycles = 0;
  bit  hold_off = 1'b0;
  bit  quiet = 1'b0;

  always #5 clk = ~clk;

  world_to_screen_projection u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  function automatic int gap_len();
    if (quiet) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && in_valid && !in_stall) sb.note_point(in_data);
    if (!rst && out_valid && !out_stall) sb.check_pixel(out_data);
  end

  // Output stall pattern; a long hold-off when requested
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else begin
        n = gap_len();
        out_stall <= (n != 0);
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    if (idx == REG_SCR_W || idx == REG_SCR_H) sb.regs[idx] = {50'd0, val[SIZE_W-1:0]};
    else sb.regs[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int n;
    n = gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{world_x: x, world_y: y, world_z: z};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Called at a falling edge right after the last request
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] q_val(int lo, int hi);
    return 32'($signed($urandom_range(0, hi - lo)) + lo) <<< FB;
  endfunction

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 8;
      default: return q_val(-200, 200) | 32'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly a sane camera so points land in front; some raw random rows
  task automatic program_matrix(bit wild);
    if (wild) begin
      for (int i = 0; i < 6; i++) write_reg(reg_idx_t'(i), {$urandom(), $urandom()});
    end else begin
      write_reg(REG_ROW0_XY, {q_val(-2, 2), q_val(-2, 2) | 32'($urandom_range(0, 65535))});
      write_reg(REG_ROW0_ZW, {q_val(-50, 50), q_val(-2, 2)});
      write_reg(REG_ROW1_XY, {q_val(-2, 2) | 32'($urandom_range(0, 65535)), q_val(-2, 2)});
      write_reg(REG_ROW1_ZW, {q_val(-50, 50), q_val(-2, 2)});
      write_reg(REG_ROW3_XY, {32'($urandom_range(0, 4095)), 32'($urandom_range(0, 4095))});
      write_reg(REG_ROW3_ZW, {q_val(0, 100), 32'h0001_0000 + $urandom_range(0, 65535)});
    end
  endtask

  initial begin
    logic [31:0] ext [4];
    logic [13:0] sizes [6];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    sizes = '{14'd0, 14'd1, 14'd8192, 14'h3FFF, 14'd1920, 14'd1081};
    sb.clear_regs();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: reset registers give w = 0, behind camera
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    drain();
    // Identity-like camera: w = z
    write_reg(REG_ROW0_XY, 64'h0000_0000_0001_0000);
    write_reg(REG_ROW0_ZW, 64'h0000_0000_0000_0000);
    write_reg(REG_ROW1_XY, 64'h0001_0000_0000_0000);
    write_reg(REG_ROW1_ZW, 64'h0000_0000_0000_0000);
    write_reg(REG_ROW3_XY, 64'h0);
    write_reg(REG_ROW3_ZW, 64'h0000_0000_0001_0000);
    send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
    send_point(32'h1, 32'h1, 32'd655);
    send_point(32'h1, 32'h1, 32'd654);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd655);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j += 1) send_point(ext[i], ext[j], ext[(i + j) % 4]);
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      program_matrix(ph % 4 == 3);
      write_reg(REG_SCR_W, 64'(ph < 6 ? sizes[ph] : 14'($urandom_range(0, 8192))));
      write_reg(REG_SCR_H, 64'(ph < 6 ? sizes[5 - ph] : 14'($urandom_range(1, 16383))));
      quiet = (ph == 5);
      if (ph == 2) hold_off = 1'b1;
      for (int k = 0; k < 125; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_point($urandom(), $urandom(), $urandom());
        else
          send_point(rnd_coord(), rnd_coord(), rnd_coord());
      end
      quiet = 1'b0;
      drain();
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
